// ===== sv/lbd_pkg.sv =====
// Shared types and constants for the literal and back-reference decompressor.
package lbd_pkg;

  localparam int HISTORY_DEPTH_DEF = 65536;
  localparam int QUEUE_DEPTH = 4;
  localparam logic [31:0] END_MARK = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_PAST    = 2'd1,
    ST_FAR     = 2'd2,
    ST_REFUSED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_LIT  = 2'd1,
    CMD_COPY = 2'd2
  } cmd_kind_t;

  // One command per accepted input word; slots travel beside it.
  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] lit;
    logic       busy;
    status_t    status;
  } cmd_t;

endpackage

// ===== sv/lbd_front.sv =====
// Front end: accepts input words, parses sections and issues commands.
module lbd_front #(
  parameter int HISTORY_DEPTH = lbd_pkg::HISTORY_DEPTH_DEF,
  parameter int AW = $clog2(HISTORY_DEPTH)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,
  input  logic                s_tuser,
  input  logic                q_full,
  output logic                q_push,
  output lbd_pkg::cmd_t       q_cmd,
  output logic [AW-1:0]       q_rd_slot,
  output logic [AW-1:0]       q_wr_slot
);

  typedef enum logic [2:0] {
    PH_LITLEN,
    PH_LITERAL,
    PH_OFFSET,
    PH_SIZE,
    PH_COPY
  } phase_t;

  phase_t        phase, phase_next;
  logic [31:0]   acc, acc_next;
  logic [1:0]    fcnt, fcnt_next;
  logic [31:0]   held_offset, held_offset_next;
  logic [31:0]   held_dist, held_dist_next;
  logic          far, far_next;
  logic [31:0]   remaining, remaining_next;
  logic [31:0]   wpos, wpos_next;
  logic [AW-1:0] wr_slot, wr_slot_next;
  logic [AW-1:0] src_slot, src_slot_next;

  logic        take;
  logic [31:0] word;
  logic        gdone;
  logic [31:0] wr_ext;
  logic [31:0] slot_sub;
  logic [31:0] slot_add;
  logic [32:0] ref_end;

  function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
    logic [AW-1:0] r;
    if (s == AW'(HISTORY_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = s + 1'b1;
    end
    return r;
  endfunction

  assign s_tready = !q_full;
  assign take     = s_tvalid && !q_full;
  assign q_push   = take;

  // little-endian field assembly
  assign word     = acc | (32'(s_tdata) << {fcnt, 3'b000});
  assign gdone    = (fcnt == 2'd3);
  assign wr_ext   = 32'(wr_slot);
  assign slot_sub = wr_ext - held_dist;
  assign slot_add = wr_ext + 32'(HISTORY_DEPTH) - held_dist;
  assign ref_end  = {1'b0, held_offset} + {1'b0, word};

  always_comb begin
    phase_next       = phase;
    acc_next         = acc;
    fcnt_next        = fcnt;
    held_offset_next = held_offset;
    held_dist_next   = held_dist;
    far_next         = far;
    remaining_next   = remaining;
    wpos_next        = wpos;
    wr_slot_next     = wr_slot;
    src_slot_next    = src_slot;
    q_cmd.kind       = lbd_pkg::CMD_NONE;
    q_cmd.lit        = 8'd0;
    q_cmd.busy       = 1'b0;
    q_cmd.status     = lbd_pkg::ST_OK;
    q_rd_slot        = src_slot;
    q_wr_slot        = wr_slot;

    if (take) begin
      if (s_tuser) begin
        if (phase == PH_COPY) begin
          q_cmd.kind     = lbd_pkg::CMD_COPY;
          wpos_next      = wpos + 32'd1;
          wr_slot_next   = slot_inc(wr_slot);
          src_slot_next  = slot_inc(src_slot);
          remaining_next = remaining - 32'd1;
          if (remaining == 32'd1) begin
            phase_next = PH_OFFSET;
          end else begin
            q_cmd.busy = 1'b1;
          end
        end
      end else begin
        case (phase)
          PH_COPY: begin
            q_cmd.status = lbd_pkg::ST_REFUSED;
            q_cmd.busy   = 1'b1;
          end
          PH_LITERAL: begin
            q_cmd.kind     = lbd_pkg::CMD_LIT;
            q_cmd.lit      = s_tdata;
            wpos_next      = wpos + 32'd1;
            wr_slot_next   = slot_inc(wr_slot);
            remaining_next = remaining - 32'd1;
            if (remaining == 32'd1) begin
              phase_next = PH_OFFSET;
            end
          end
          PH_LITLEN: begin
            fcnt_next = fcnt + 2'd1;
            if (gdone) begin
              acc_next       = '0;
              remaining_next = word;
              phase_next     = (word == 32'd0) ? PH_OFFSET : PH_LITERAL;
            end else begin
              acc_next = word;
            end
          end
          PH_OFFSET: begin
            fcnt_next = fcnt + 2'd1;
            if (gdone) begin
              acc_next = '0;
              if (word == lbd_pkg::END_MARK) begin
                phase_next = PH_LITLEN;
              end else begin
                held_offset_next = word;
                held_dist_next   = wpos - word;
                phase_next       = PH_SIZE;
              end
            end else begin
              acc_next = word;
            end
          end
          PH_SIZE: begin
            fcnt_next = fcnt + 2'd1;
            // resolve window check and source slot while size bytes arrive
            if (fcnt == 2'd0) begin
              far_next      = (held_dist > 32'(HISTORY_DEPTH));
              src_slot_next = (held_dist <= wr_ext) ? slot_sub[AW-1:0] : slot_add[AW-1:0];
            end
            if (gdone) begin
              acc_next   = '0;
              phase_next = PH_OFFSET;
              if (word == 32'd0) begin
                q_cmd.status = lbd_pkg::ST_OK;
              end else if (ref_end > {1'b0, wpos}) begin
                q_cmd.status = lbd_pkg::ST_PAST;
              end else if (far) begin
                q_cmd.status = lbd_pkg::ST_FAR;
              end else begin
                remaining_next = word;
                phase_next     = PH_COPY;
                q_cmd.busy     = 1'b1;
              end
            end else begin
              acc_next = word;
            end
          end
          default: begin
            phase_next = PH_LITLEN;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_LITLEN;
      acc         <= '0;
      fcnt        <= '0;
      held_offset <= '0;
      held_dist   <= '0;
      far         <= 1'b0;
      remaining   <= '0;
      wpos        <= '0;
      wr_slot     <= '0;
      src_slot    <= '0;
    end else begin
      phase       <= phase_next;
      acc         <= acc_next;
      fcnt        <= fcnt_next;
      held_offset <= held_offset_next;
      held_dist   <= held_dist_next;
      far         <= far_next;
      remaining   <= remaining_next;
      wpos        <= wpos_next;
      wr_slot     <= wr_slot_next;
      src_slot    <= src_slot_next;
    end
  end

endmodule

// ===== sv/lbd_queue.sv =====
// Small register queue between the front end and the back end.
module lbd_queue #(
  parameter int W = 8,
  parameter int DEPTH = lbd_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] head,
  output logic         empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  entries [DEPTH];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [CW-1:0] count;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    if (p == PW'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wp] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= ptr_inc(wp);
      end
      if (pop) begin
        rp <= ptr_inc(rp);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== sv/lbd_back.sv =====
// Back end: history memory, copy reads with write forwarding, output register.
module lbd_back #(
  parameter int HISTORY_DEPTH = lbd_pkg::HISTORY_DEPTH_DEF,
  parameter int AW = $clog2(HISTORY_DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  lbd_pkg::cmd_t q_cmd,
  input  logic [AW-1:0] q_rd_slot,
  input  logic [AW-1:0] q_wr_slot,
  output logic          q_pop,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [15:0]   m_tdata,
  output logic          m_tuser
);

  logic [7:0]    history [HISTORY_DEPTH];

  logic          b_valid;
  lbd_pkg::cmd_t b_cmd;
  logic [AW-1:0] b_wr_slot;
  logic          b_fwd;
  logic [7:0]    b_fwd_data;
  logic [7:0]    rd_data;

  logic          b_move;
  logic          b_emits;
  logic [7:0]    b_data;

  assign b_move  = b_valid && (!m_tvalid || m_tready);
  assign q_pop   = !q_empty && (!b_valid || b_move);
  assign b_emits = (b_cmd.kind != lbd_pkg::CMD_NONE);

  always_comb begin
    case (b_cmd.kind)
      lbd_pkg::CMD_LIT:  b_data = b_cmd.lit;
      lbd_pkg::CMD_COPY: b_data = b_fwd ? b_fwd_data : rd_data;
      default:           b_data = 8'd0;
    endcase
  end

  // write retires with the word leaving stage b; read is issued on pop
  always_ff @(posedge clk) begin
    if (b_move && b_emits) begin
      history[b_wr_slot] <= b_data;
    end
    if (q_pop) begin
      rd_data <= history[q_rd_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (q_pop) begin
        b_valid <= 1'b1;
      end else if (b_move) begin
        b_valid <= 1'b0;
      end
      if (b_move) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b_cmd      <= q_cmd;
      b_wr_slot  <= q_wr_slot;
      // read collides with the byte being written this same edge
      b_fwd      <= b_move && b_emits && (b_wr_slot == q_rd_slot);
      b_fwd_data <= b_data;
    end
    if (b_move) begin
      m_tdata <= {5'b00000, b_cmd.status, b_cmd.busy, b_data};
      m_tuser <= b_emits;
    end
  end

endmodule

// ===== sv/literal_and_backref_decompressor.sv =====
// Top level of the literal and back-reference decompressor.
//
//  channel  dir  tdata                                       tuser
//  s_*      in   [7:0] in_byte                               operation (1 = tick)
//  m_*      out  [7:0] out_byte, [8] copy_busy, [10:9] status out_valid
//
// One input word is taken per cycle while s_tready is high and gives one output
// word; the path from input handshake to output valid runs through the queue
// entry, the memory read stage and the output register.
// The history memory takes one read and one write per cycle; a copy that reads the
// byte written in the same cycle gets it forwarded.
// rst is synchronous; the history memory is not cleared.
// A stalled output fills the queue, then drops s_tready.
module literal_and_backref_decompressor #(
  parameter int HISTORY_DEPTH = lbd_pkg::HISTORY_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tuser,   // [0] operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] out_byte, [8] copy_busy, [10:9] status
  output logic        m_tuser    // [0] out_valid
);

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int CMDW = $bits(lbd_pkg::cmd_t);
  localparam int QW = CMDW + 2 * AW;

  logic          q_full;
  logic          q_push;
  lbd_pkg::cmd_t f_cmd;
  logic [AW-1:0] f_rd_slot;
  logic [AW-1:0] f_wr_slot;
  logic          q_pop;
  logic          q_empty;
  logic [QW-1:0] q_head;
  lbd_pkg::cmd_t h_cmd;
  logic [AW-1:0] h_rd_slot;
  logic [AW-1:0] h_wr_slot;

  assign h_cmd     = lbd_pkg::cmd_t'(q_head[QW-1 -: CMDW]);
  assign h_rd_slot = q_head[2*AW-1 -: AW];
  assign h_wr_slot = q_head[AW-1:0];

  lbd_front #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .AW            (AW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (f_cmd),
    .q_rd_slot (f_rd_slot),
    .q_wr_slot (f_wr_slot)
  );

  lbd_queue #(
    .W     (QW),
    .DEPTH (lbd_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data ({f_cmd, f_rd_slot, f_wr_slot}),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  lbd_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .AW            (AW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_cmd     (h_cmd),
    .q_rd_slot (h_rd_slot),
    .q_wr_slot (h_wr_slot),
    .q_pop     (q_pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule
